[design/mlft_pkg.sv]
// Package for the MAC learning forwarding table.
// Holds table sizes, field widths, outcome and command codes and the match status type.
// No dependencies.
package mlft_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   localparam int MAC_W = 48;
   localparam int IP_W = 32;
   localparam int PORT_W = 16;
   localparam int PEER_W = IP_W + PORT_W;
   localparam int ENTRY_W = MAC_W + PEER_W;
   localparam int OC_W = 3;

   localparam logic [MAC_W-1:0] BCAST_MAC = {MAC_W{1'b1}};

   typedef enum logic {
      CMD_LEARN = 1'b0,
      CMD_FORWARD = 1'b1
   } command_type;

   typedef enum logic [OC_W-1:0] {
      OC_LEARNED = 3'd0,
      OC_KNOWN = 3'd1,
      OC_FULL = 3'd2,
      OC_HIT = 3'd3,
      OC_DEFAULT = 3'd4,
      OC_FLOOD = 3'd5,
      OC_FLOOD_EMPTY = 3'd6
   } outcome_type;

   // Result of comparing one stored entry against the key.
   typedef struct packed {
      logic hit;     // stored address equals the key
      logic at_end;  // entry is the last valid one
      logic full;    // table holds TABLE_DEPTH entries
   } match_type;

endpackage

[design/mlft_if.sv]
// Handshake channels of the MAC learning forwarding table: request and response.
// Depends on mlft_pkg for field widths.
interface mlft_req_if import mlft_pkg::*; ;
   logic              valid;
   logic              ready;
   logic              command;
   logic [MAC_W-1:0]  mac_address;
   logic [IP_W-1:0]   peer_ip;
   logic [PORT_W-1:0] peer_port;

   modport source (output valid, output command, output mac_address, output peer_ip,
                   output peer_port, input ready);
   modport sink (input valid, input command, input mac_address, input peer_ip,
                 input peer_port, output ready);
endinterface

interface mlft_rsp_if import mlft_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [OC_W-1:0]   outcome;
   logic [IP_W-1:0]   dest_ip;
   logic [PORT_W-1:0] dest_port;
   logic              last;

   modport source (output valid, output outcome, output dest_ip, output dest_port,
                   output last, input ready);
   modport sink (input valid, input outcome, input dest_ip, input dest_port,
                 input last, output ready);
endinterface

[design/mlft_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies; read data holds while no read is issued.
module mlft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/mlft_match.sv]
// Shared compare unit: checks one entry read from the table against the key.
// Depends on mlft_pkg.
module mlft_match import mlft_pkg::*; (
   input  logic [MAC_W-1:0] key,
   input  logic [MAC_W-1:0] entry_mac,
   input  logic [IDX_W-1:0] idx,
   input  logic [CNT_W-1:0] count,
   output match_type        status
);

   always_comb begin
      status.hit = (entry_mac == key);
      status.at_end = ((CNT_W'(idx) + CNT_W'(1)) == count);
      status.full = (count == CNT_W'(TABLE_DEPTH));
   end

endmodule

[design/mac_learning_forward_table_top.sv]
// MAC learning forwarding table, top level.
// Request item: command (learn / forward), mac_address, peer_ip, peer_port.
// Response item: outcome, dest_ip, dest_port, last. Both are valid/ready channels;
// an item moves on a rising edge with valid and ready high.
// The table lives in one RAM (address plus endpoint per row) and is scanned one
// row at a time by a single 48-bit comparator: each row goes through a read state
// and then a compare state. A request is taken only while the sequencer is idle.
// Learn or unicast forward: rows are scanned up to the stored count; a unicast miss
// then fetches row 0 for the default result. Empty table: result from the start state.
// Broadcast forward: one flood item per stored row, last set on the final one; the
// scan waits while the output slot is full. Throughput is bounded by the RAM read
// port and comparator. The response is registered: a new request is taken while a
// result waits, and a stalled receiver holds the sequencer at its next result.
// Reset (synchronous) empties the table by clearing the entry count; RAM rows
// are never read beyond the count, so no clearing pass is needed.
// Depends on mlft_pkg, mlft_if, mlft_ram and mlft_match.
module mac_learning_forward_table_top import mlft_pkg::*; (
   input logic          clock,
   input logic          reset,
   mlft_req_if.sink     req,
   mlft_rsp_if.source   rsp
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_START,
      S_READ,
      S_CMP,
      S_DEF_READ,
      S_DEF_OUT
   } state_type;

   state_type         state_ff, state_in;
   logic              cmd_ff, cmd_in;
   logic [MAC_W-1:0]  mac_ff, mac_in;
   logic [PEER_W-1:0] peer_ff, peer_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [OC_W-1:0]   rsp_outcome_ff, rsp_outcome_in;
   logic [IP_W-1:0]   rsp_ip_ff, rsp_ip_in;
   logic [PORT_W-1:0] rsp_port_ff, rsp_port_in;
   logic              rsp_last_ff, rsp_last_in;

   logic               slot_free;
   logic               emit;
   outcome_type        emit_oc;
   logic [PEER_W-1:0]  emit_peer;
   logic               emit_last;
   logic               is_learn;
   logic               is_flood;
   logic               wr_en;
   logic               rd_en;
   logic [ENTRY_W-1:0] rd_data;
   logic [PEER_W-1:0]  rd_peer;
   match_type          status;

   mlft_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data ({mac_ff, peer_ff}),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   mlft_match u_match (
      .key       (mac_ff),
      .entry_mac (rd_data[ENTRY_W-1:PEER_W]),
      .idx       (idx_ff),
      .count     (count_ff),
      .status    (status)
   );

   assign rd_peer = rd_data[PEER_W-1:0];
   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign is_learn = (cmd_ff == CMD_LEARN);
   assign is_flood = (cmd_ff == CMD_FORWARD) && (mac_ff == BCAST_MAC);
   assign rd_en = (state_ff == S_READ) || (state_ff == S_DEF_READ);

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      mac_in = mac_ff;
      peer_in = peer_ff;
      idx_in = idx_ff;
      count_in = count_ff;
      emit = 1'b0;
      emit_oc = OC_LEARNED;
      emit_peer = '0;
      emit_last = 1'b1;
      wr_en = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               cmd_in = req.command;
               mac_in = req.mac_address;
               peer_in = {req.peer_ip, req.peer_port};
               idx_in = '0;
               state_in = S_START;
            end
         end
         S_START: begin
            if (count_ff != '0) begin
               state_in = S_READ;
            end else if (slot_free) begin
               emit = 1'b1;
               if (is_learn) begin
                  emit_oc = OC_LEARNED;
                  wr_en = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end else if (is_flood) begin
                  emit_oc = OC_FLOOD_EMPTY;
               end else begin
                  emit_oc = OC_DEFAULT;
               end
               state_in = S_IDLE;
            end
         end
         S_READ: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            priority if (is_flood) begin
               if (slot_free) begin
                  emit = 1'b1;
                  emit_oc = OC_FLOOD;
                  emit_peer = rd_peer;
                  emit_last = status.at_end;
                  if (status.at_end) begin
                     state_in = S_IDLE;
                  end else begin
                     idx_in = idx_ff + IDX_W'(1);
                     state_in = S_READ;
                  end
               end
            end else if (status.hit) begin
               if (slot_free) begin
                  emit = 1'b1;
                  emit_oc = is_learn ? OC_KNOWN : OC_HIT;
                  emit_peer = is_learn ? '0 : rd_peer;
                  state_in = S_IDLE;
               end
            end else if (status.at_end) begin
               if (is_learn) begin
                  if (slot_free) begin
                     emit = 1'b1;
                     if (status.full) begin
                        emit_oc = OC_FULL;
                     end else begin
                        emit_oc = OC_LEARNED;
                        wr_en = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                     state_in = S_IDLE;
                  end
               end else begin
                  // miss: fall back to row 0
                  idx_in = '0;
                  state_in = S_DEF_READ;
               end
            end else begin
               idx_in = idx_ff + IDX_W'(1);
               state_in = S_READ;
            end
         end
         S_DEF_READ: begin
            state_in = S_DEF_OUT;
         end
         S_DEF_OUT: begin
            if (slot_free) begin
               emit = 1'b1;
               emit_oc = OC_DEFAULT;
               emit_peer = rd_peer;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_ip_in = rsp_ip_ff;
      rsp_port_in = rsp_port_ff;
      rsp_last_in = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_outcome_in = emit_oc;
         rsp_ip_in = emit_peer[PEER_W-1:PORT_W];
         rsp_port_in = emit_peer[PORT_W-1:0];
         rsp_last_in = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in;
      mac_ff <= mac_in;
      peer_ff <= peer_in;
      idx_ff <= idx_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_ip_ff <= rsp_ip_in;
      rsp_port_ff <= rsp_port_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.outcome = rsp_outcome_ff;
   assign rsp.dest_ip = rsp_ip_ff;
   assign rsp.dest_port = rsp_port_ff;
   assign rsp.last = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_learn_grows: assert property (@(posedge clock) disable iff (reset)
      (emit && emit_oc == OC_LEARNED) |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("learned item did not grow the table");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (emit && emit_last) |=> state_ff == S_IDLE)
      else $error("sequencer busy after final item");

   a_no_write_full: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (count_ff < CNT_W'(TABLE_DEPTH)) && emit)
      else $error("table write without room or without result");
`endif

endmodule
